// ===== sv/dcsp_pkg.sv =====
package dcsp_pkg;

    localparam logic [29:0] MODP       = 30'd1000000007;
    localparam logic [29:0] MODQ       = 30'd1000000006;
    localparam logic [30:0] MODP_EXP   = 31'd1000000005;
    localparam int          MUL_STEPS  = 30;

    typedef struct packed {
        logic [19:0] prime_value;
        logic [29:0] prime_power;
        logic        last_term;
    } dcsp_in_t;

    typedef struct packed {
        logic [29:0] divisor_count;
        logic [29:0] divisor_sum;
        logic [29:0] divisor_product;
    } dcsp_out_t;

    typedef struct packed {
        logic        go;
        logic [29:0] a;
        logic [29:0] b;
        logic [29:0] m;
    } dcsp_mul_req_t;

    typedef struct packed {
        logic        done;
        logic [29:0] res;
    } dcsp_mul_rsp_t;

    // one conditional subtract; x must be below 2*m
    function automatic logic [29:0] red_once(input logic [30:0] x, input logic [29:0] m);
        logic [30:0] d;
        d = x - {1'b0, m};
        red_once = (x >= {1'b0, m}) ? d[29:0] : x[29:0];
    endfunction

endpackage

// ===== sv/dcsp_modmul.sv =====
module dcsp_modmul
    import dcsp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  dcsp_mul_req_t req,
    output dcsp_mul_rsp_t rsp
);

    logic [29:0] a_reg, b_reg, m_reg, r_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;

    logic [31:0] t, t1, t2, m1, m2;

    always_comb begin
        m1 = {2'b00, m_reg};
        m2 = {1'b0, m_reg, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (b_reg[29] ? {2'b00, a_reg} : 32'd0);
        t1 = t - m1;
        t2 = t - m2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.go && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(MUL_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // MSB-first shift-and-add, reduced each step
    always_ff @(posedge aclk) begin
        if (req.go && !busy_reg) begin
            a_reg <= req.a;
            b_reg <= req.b;
            m_reg <= req.m;
            r_reg <= '0;
        end else if (busy_reg) begin
            b_reg <= {b_reg[28:0], 1'b0};
            if (t >= m2)
                r_reg <= t2[29:0];
            else if (t >= m1)
                r_reg <= t1[29:0];
            else
                r_reg <= t[29:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = r_reg;

endmodule

// ===== sv/divisor_count_sum_product.sv =====
// Divisor count, sum and product modulo 1000000007 from a prime factorization.
// Input channel (s_valid/s_ready/s_payload): one beat per term, a prime, its
// exponent and a flag on the last term. Result channel (m_valid/m_ready/
// m_payload): one beat per factorization, after the flagged term.
// All products and powers run on one 30-step shift-and-add modular
// multiplier. A term takes one count product, the powers p^(e+1) and
// (p-1)^1000000005, and two products. After the last term, each stored term
// takes one product modulo 1000000006 for its exponent factor, then a product
// for its reduced product exponent, a power and a product into the result.
// s_ready is high only while the sequencer is idle. A finished result sits in
// the output register; the next term is taken while it waits, but a new
// result holds in the sequencer until the receiver takes the old one.
// Terms beyond MAX_TERMS are dropped from all three values.
// Reset (aresetn low, synchronous) empties the term buffer, sets count and
// sum to one and drops any pending result.
module divisor_count_sum_product
    import dcsp_pkg::*;
#(
    parameter int MAX_TERMS = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dcsp_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output dcsp_out_t m_payload
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CNT   = 5'd1;
    localparam logic [4:0] ST_PW    = 5'd2;
    localparam logic [4:0] ST_PW_M  = 5'd3;
    localparam logic [4:0] ST_PW_S  = 5'd4;
    localparam logic [4:0] ST_NUM   = 5'd5;
    localparam logic [4:0] ST_DEN   = 5'd6;
    localparam logic [4:0] ST_F     = 5'd7;
    localparam logic [4:0] ST_SUM   = 5'd8;
    localparam logic [4:0] ST_FSTRT = 5'd9;
    localparam logic [4:0] ST_FRD   = 5'd10;
    localparam logic [4:0] ST_FWAIT = 5'd11;
    localparam logic [4:0] ST_FMUL  = 5'd12;
    localparam logic [4:0] ST_PSTRT = 5'd13;
    localparam logic [4:0] ST_PRD   = 5'd14;
    localparam logic [4:0] ST_PWAIT = 5'd15;
    localparam logic [4:0] ST_PK    = 5'd16;
    localparam logic [4:0] ST_PACC  = 5'd17;
    localparam logic [4:0] ST_PPM   = 5'd18;
    localparam logic [4:0] ST_DONE  = 5'd19;

    logic [4:0]       state_reg, state_next, ret_reg, ret_next;
    logic [29:0]      cnt_acc_reg, cnt_acc_next, sum_acc_reg, sum_acc_next;
    logic [CNT_W-1:0] tc_reg, tc_next, idx_reg, idx_next;
    logic             odd_reg, odd_next, last_reg, last_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [19:0]      p_reg, p_next;
    logic [29:0]      e_reg, e_next;
    logic [29:0]      base_reg, base_next, pres_reg, pres_next;
    logic [30:0]      exp_reg, exp_next;
    logic [29:0]      tmp_reg, tmp_next, d_reg, d_next, prod_reg, prod_next;
    logic             mv_reg, mv_next;
    dcsp_out_t        out_reg, out_next;

    logic [19:0]      mem_p [MAX_TERMS];
    logic [29:0]      mem_e [MAX_TERMS];
    logic [19:0]      q_p;
    logic [29:0]      q_e;
    logic             wr_en;

    dcsp_mul_req_t    req;
    dcsp_mul_rsp_t    rsp;

    logic [30:0]      f_raw;
    logic [29:0]      k_raw;

    dcsp_modmul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_p[tc_reg[IDX_W-1:0]] <= s_payload.prime_value;
            mem_e[tc_reg[IDX_W-1:0]] <= s_payload.prime_power;
        end
        q_p <= mem_p[idx_reg[IDX_W-1:0]];
        q_e <= mem_e[idx_reg[IDX_W-1:0]];
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = mv_reg;
    assign m_payload = out_reg;

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cnt_acc_next = cnt_acc_reg;
        sum_acc_next = sum_acc_reg;
        tc_next      = tc_reg;
        idx_next     = idx_reg;
        odd_next     = odd_reg;
        last_next    = last_reg;
        slot_next    = slot_reg;
        p_next       = p_reg;
        e_next       = e_reg;
        base_next    = base_reg;
        pres_next    = pres_reg;
        exp_next     = exp_reg;
        tmp_next     = tmp_reg;
        d_next       = d_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        mv_next      = mv_reg && !m_ready;
        wr_en        = 1'b0;
        req          = '0;
        req.m        = MODP;

        f_raw = {1'b0, q_e} + 31'd1;
        if (odd_reg && (idx_reg[IDX_W-1:0] == slot_reg))
            f_raw = f_raw >> 1;
        k_raw = odd_reg ? q_e : (q_e >> 1);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_next    = s_payload.prime_value;
                    e_next    = s_payload.prime_power;
                    last_next = s_payload.last_term;
                    if (tc_reg < CNT_W'(MAX_TERMS)) begin
                        wr_en   = 1'b1;
                        tc_next = tc_reg + CNT_W'(1);
                        if (s_payload.prime_power[0]) begin
                            odd_next  = 1'b1;
                            slot_next = tc_reg[IDX_W-1:0];
                        end
                        req.go     = 1'b1;
                        req.a      = cnt_acc_reg;
                        req.b      = red_once({1'b0, s_payload.prime_power} + 31'd1, MODP);
                        state_next = ST_CNT;
                    end else if (s_payload.last_term) begin
                        state_next = ST_FSTRT;
                    end
                end
            end
            ST_CNT: begin
                if (rsp.done) begin
                    cnt_acc_next = rsp.res;
                    base_next    = {10'd0, p_reg};
                    exp_next     = {1'b0, e_reg} + 31'd1;
                    pres_next    = 30'd1;
                    ret_next     = ST_NUM;
                    state_next   = ST_PW;
                end
            end
            ST_PW: begin
                if (exp_reg == '0) begin
                    state_next = ret_reg;
                end else if (exp_reg[0]) begin
                    req.go     = 1'b1;
                    req.a      = pres_reg;
                    req.b      = base_reg;
                    state_next = ST_PW_M;
                end else begin
                    req.go     = 1'b1;
                    req.a      = base_reg;
                    req.b      = base_reg;
                    state_next = ST_PW_S;
                end
            end
            ST_PW_M: begin
                if (rsp.done) begin
                    pres_next  = rsp.res;
                    req.go     = 1'b1;
                    req.a      = base_reg;
                    req.b      = base_reg;
                    state_next = ST_PW_S;
                end
            end
            ST_PW_S: begin
                if (rsp.done) begin
                    base_next  = rsp.res;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_PW;
                end
            end
            ST_NUM: begin
                tmp_next   = (pres_reg == '0) ? (MODP - 30'd1) : (pres_reg - 30'd1);
                // base of zero wraps to p-1 = MODP-1
                base_next  = (p_reg == '0) ? (MODP - 30'd1) : ({10'd0, p_reg} - 30'd1);
                exp_next   = MODP_EXP;
                pres_next  = 30'd1;
                ret_next   = ST_DEN;
                state_next = ST_PW;
            end
            ST_DEN: begin
                req.go     = 1'b1;
                req.a      = tmp_reg;
                req.b      = pres_reg;
                state_next = ST_F;
            end
            ST_F: begin
                if (rsp.done) begin
                    req.go     = 1'b1;
                    req.a      = sum_acc_reg;
                    req.b      = rsp.res;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (rsp.done) begin
                    sum_acc_next = rsp.res;
                    state_next   = last_reg ? ST_FSTRT : ST_IDLE;
                end
            end
            ST_FSTRT: begin
                d_next     = 30'd1;
                idx_next   = '0;
                state_next = ST_FRD;
            end
            ST_FRD: begin
                state_next = (idx_reg == tc_reg) ? ST_PSTRT : ST_FWAIT;
            end
            ST_FWAIT: begin
                req.go     = 1'b1;
                req.m      = MODQ;
                req.a      = d_reg;
                req.b      = red_once(f_raw, MODQ);
                state_next = ST_FMUL;
            end
            ST_FMUL: begin
                req.m = MODQ;
                if (rsp.done) begin
                    d_next     = rsp.res;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_FRD;
                end
            end
            ST_PSTRT: begin
                prod_next  = 30'd1;
                idx_next   = '0;
                state_next = ST_PRD;
            end
            ST_PRD: begin
                state_next = (idx_reg == tc_reg) ? ST_DONE : ST_PWAIT;
            end
            ST_PWAIT: begin
                req.go     = 1'b1;
                req.m      = MODQ;
                req.a      = red_once({1'b0, k_raw}, MODQ);
                req.b      = d_reg;
                state_next = ST_PK;
            end
            ST_PK: begin
                req.m = MODQ;
                if (rsp.done) begin
                    base_next  = {10'd0, q_p};
                    exp_next   = {1'b0, rsp.res};
                    pres_next  = 30'd1;
                    ret_next   = ST_PACC;
                    state_next = ST_PW;
                end
            end
            ST_PACC: begin
                req.go     = 1'b1;
                req.a      = prod_reg;
                req.b      = pres_reg;
                state_next = ST_PPM;
            end
            ST_PPM: begin
                if (rsp.done) begin
                    prod_next  = rsp.res;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_PRD;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!mv_reg || m_ready) begin
                    mv_next                  = 1'b1;
                    out_next.divisor_count   = cnt_acc_reg;
                    out_next.divisor_sum     = sum_acc_reg;
                    out_next.divisor_product = prod_reg;
                    cnt_acc_next             = 30'd1;
                    sum_acc_next             = 30'd1;
                    tc_next                  = '0;
                    odd_next                 = 1'b0;
                    slot_next                = '0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            cnt_acc_reg <= 30'd1;
            sum_acc_reg <= 30'd1;
            tc_reg      <= '0;
            idx_reg     <= '0;
            odd_reg     <= 1'b0;
            slot_reg    <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cnt_acc_reg <= cnt_acc_next;
            sum_acc_reg <= sum_acc_next;
            tc_reg      <= tc_next;
            idx_reg     <= idx_next;
            odd_reg     <= odd_next;
            slot_reg    <= slot_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        p_reg    <= p_next;
        e_reg    <= e_next;
        base_reg <= base_next;
        pres_reg <= pres_next;
        exp_reg  <= exp_next;
        tmp_reg  <= tmp_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    a_tc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tc_reg <= CNT_W'(MAX_TERMS))
        else $error("term count beyond buffer depth");

    a_slot_held: assert property (@(posedge aclk) disable iff (!aresetn)
        odd_reg |-> ({{(CNT_W-IDX_W){1'b0}}, slot_reg} < tc_reg))
        else $error("odd exponent slot outside stored terms");

    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_CNT || state_reg == ST_PW_M || state_reg == ST_PW_S
                      || state_reg == ST_F || state_reg == ST_SUM || state_reg == ST_FMUL
                      || state_reg == ST_PK || state_reg == ST_PPM))
        else $error("multiplier result arrived outside a wait state");

endmodule

// ===== sim/divisor_count_sum_product_tb.sv =====
`timescale 1ns / 100ps

module divisor_count_sum_product_tb;
    import dcsp_pkg::*;

    localparam int       TERM_SLOTS  = 256;
    localparam int       SETTLE_CYC  = 12000;
    localparam longint unsigned PRIME_M = 64'd1000000007;
    localparam longint unsigned ORDER_M = 64'd1000000006;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dcsp_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dcsp_out_t m_payload;

    divisor_count_sum_product i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;

    dcsp_out_t divisor_results_q[$];

    // predictor state
    longint unsigned count_acc;
    longint unsigned sum_acc;
    logic [19:0]     held_primes[TERM_SLOTS];
    logic [29:0]     held_powers[TERM_SLOTS];
    int              held_terms;
    bit              odd_seen;
    int              odd_slot;

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned k);
        longint unsigned r;
        r = 1;
        b = b % PRIME_M;
        while (k != 0) begin
            if (k[0]) r = (r * b) % PRIME_M;
            b = (b * b) % PRIME_M;
            k = k >> 1;
        end
        return r;
    endfunction

    function automatic longint unsigned geo_series(longint unsigned p, longint unsigned e);
        longint unsigned num;
        longint unsigned den;
        num = (pow_mod(p, e + 1) + PRIME_M - 1) % PRIME_M;
        den = pow_mod((p + PRIME_M - 1) % PRIME_M, PRIME_M - 2);
        return (num * den) % PRIME_M;
    endfunction

    task automatic clear_factorization();
        count_acc  = 1;
        sum_acc    = 1;
        held_terms = 0;
        odd_seen   = 1'b0;
        odd_slot   = 0;
    endtask

    task automatic predict_term(input dcsp_in_t t);
        longint unsigned p;
        longint unsigned e;
        longint unsigned d;
        longint unsigned f;
        longint unsigned k;
        longint unsigned prod;
        dcsp_out_t       r;
        p = t.prime_value;
        e = t.prime_power;
        if (held_terms < TERM_SLOTS) begin
            held_primes[held_terms] = t.prime_value;
            held_powers[held_terms] = t.prime_power;
            if (e[0]) begin
                odd_seen = 1'b1;
                odd_slot = held_terms;
            end
            held_terms++;
            count_acc = (count_acc * ((e + 1) % PRIME_M)) % PRIME_M;
            sum_acc   = (sum_acc * geo_series(p, e)) % PRIME_M;
        end
        if (t.last_term) begin
            d = 1;
            for (int i = 0; i < held_terms; i++) begin
                f = longint'(held_powers[i]) + 1;
                if (odd_seen && i == odd_slot) f = f >> 1;
                d = (d * (f % ORDER_M)) % ORDER_M;
            end
            prod = 1;
            for (int i = 0; i < held_terms; i++) begin
                k = odd_seen ? longint'(held_powers[i]) : longint'(held_powers[i] >> 1);
                k = ((k % ORDER_M) * d) % ORDER_M;
                prod = (prod * pow_mod(held_primes[i], k)) % PRIME_M;
            end
            r.divisor_count   = count_acc[29:0];
            r.divisor_sum     = sum_acc[29:0];
            r.divisor_product = prod[29:0];
            divisor_results_q.push_back(r);
            clear_factorization();
        end
    endtask

    // receiver: random backpressure and result checking
    always @(posedge aclk) begin
        dcsp_out_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (divisor_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: count %0d sum %0d product %0d",
                             m_payload.divisor_count, m_payload.divisor_sum,
                             m_payload.divisor_product);
            end else begin
                want = divisor_results_q.pop_front();
                if (m_payload !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.divisor_count, want.divisor_sum,
                                 want.divisor_product, m_payload.divisor_count,
                                 m_payload.divisor_sum, m_payload.divisor_product);
                end
            end
        end
    end

    task automatic send_term(input logic [19:0] p, input logic [29:0] e, input logic last);
        dcsp_in_t t;
        t.prime_value = p;
        t.prime_power = e;
        t.last_term   = last;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= t;
        do @(posedge aclk); while (!s_ready);
        predict_term(t);
    endtask

    // hold off until every expected result is in and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        while (divisor_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic logic [19:0] pick_prime();
        case ($urandom_range(3))
            0: return 20'($urandom_range(0, 40));
            1: return 20'hFFFFF - 20'($urandom_range(0, 3));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [29:0] pick_power();
        if ($urandom_range(99) < 60) return 30'($urandom_range(0, 9));
        return 30'($urandom);
    endfunction

    task automatic test_directed();
        send_term(20'd2, 30'd1, 1'b1);
        send_term(20'd2, 30'd2, 1'b0);
        send_term(20'd3, 30'd4, 1'b1);
        send_term(20'd3, 30'd1, 1'b0);
        send_term(20'd5, 30'd3, 1'b0);
        send_term(20'd7, 30'd2, 1'b1);
        send_term(20'd1, 30'd5, 1'b1);
        send_term(20'd0, 30'd0, 1'b1);
        send_term(20'd0, 30'd3, 1'b0);
        send_term(20'd11, 30'd0, 1'b1);
        send_term(20'hFFFFF, 30'h3FFFFFFF, 1'b1);
        send_term(20'hFFFFF, 30'h3FFFFFFE, 1'b0);
        send_term(20'd1048573, 30'h2AAAAAAA, 1'b1);
        send_term(20'd13, 30'h15555555, 1'b0);
        send_term(20'd1, 30'd0, 1'b1);
        drain();
    endtask

    task automatic test_buffer_full();
        for (int i = 0; i < TERM_SLOTS + 2; i++)
            send_term(20'($urandom_range(2, 50)), 30'($urandom_range(0, 3)),
                      i == TERM_SLOTS + 1);
        drain();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int i = 0; i < n; i++)
            send_term(pick_prime(), pick_power(), ($urandom_range(5) == 0) || (i == n - 1));
        drain();
    endtask

    initial begin
        clear_factorization();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_buffer_full();
        test_random(0, 0, 220);
        test_random(49, 0, 220);
        test_random(0, 49, 220);
        test_random(12, 12, 220);
        test_random(0, 0, 10);
        if (mismatch_count == 0 && divisor_results_q.size() == 0)
            $display("[divisor_count_sum_product] OK");
        else
            $display("[divisor_count_sum_product] ERROR");
        $finish;
    end

    initial begin
        #800ms;
        $display("[divisor_count_sum_product] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dcsp_pkg.sv
sv/dcsp_modmul.sv
sv/divisor_count_sum_product.sv
sim/divisor_count_sum_product_tb.sv
